>>> src/olirs_pkg.sv
package olirs_pkg;

    localparam int CAPACITY_DEF      = 64;
    localparam int ELEMENT_WIDTH_DEF = 32;

    localparam int CMD_W   = 2;
    localparam int POS_W   = 7;
    localparam int VAL_W   = 32;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 56;

    typedef enum logic [CMD_W-1:0] {
        OP_INSERT = 2'd0,
        OP_REMOVE = 2'd1,
        OP_SEARCH = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    // Broadcast to every cell in the execute cycle
    typedef struct packed {
        logic shift_ins;
        logic shift_rem;
    } cell_ctrl_t;

endpackage

>>> src/olirs_cell.sv
module olirs_cell #(
    parameter int ELEMENT_WIDTH = olirs_pkg::ELEMENT_WIDTH_DEF,
    parameter int IDX_W         = 6,
    parameter int CNT_W         = 7,
    parameter int INDEX         = 0
) (
    input  logic                     aclk,
    input  olirs_pkg::cell_ctrl_t    ctrl,
    input  logic [IDX_W-1:0]         k_idx,
    input  logic [CNT_W-1:0]         count,
    input  logic [ELEMENT_WIDTH-1:0] item_val,
    input  logic [ELEMENT_WIDTH-1:0] left_data,
    input  logic [ELEMENT_WIDTH-1:0] right_data,
    output logic [ELEMENT_WIDTH-1:0] data_out,
    output logic                     match,
    output logic [ELEMENT_WIDTH-1:0] sel_data
);
    import olirs_pkg::*;

    logic [ELEMENT_WIDTH-1:0] data_reg;
    logic [ELEMENT_WIDTH-1:0] data_next;
    logic                     is_valid;
    logic                     at_k;
    logic                     above_k;

    assign is_valid = CNT_W'(INDEX) < count;
    assign at_k     = IDX_W'(INDEX) == k_idx;
    assign above_k  = IDX_W'(INDEX) > k_idx;

    always_comb begin
        data_next = data_reg;
        if (ctrl.shift_ins) begin
            if (above_k) begin
                data_next = left_data;
            end else if (at_k) begin
                data_next = item_val;
            end
        end else if (ctrl.shift_rem) begin
            // close the gap: everything from the removed slot up moves down
            if (above_k || at_k) begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data_out = data_reg;
    assign match    = is_valid && (data_reg == item_val);
    assign sel_data = at_k ? data_reg : '0;

endmodule

>>> src/olirs_first_match.sv
module olirs_first_match #(
    parameter int WIDTH = olirs_pkg::CAPACITY_DEF,
    parameter int IDX_W = 6
) (
    input  logic [WIDTH-1:0] match,
    output logic             any,
    output logic [IDX_W-1:0] index
);
    import olirs_pkg::*;

    logic [WIDTH-1:0] first_hot;

    // isolate the lowest set bit
    assign first_hot = match & (~match + WIDTH'(1));
    assign any       = |match;

    always_comb begin
        index = '0;
        for (int i = 0; i < WIDTH; i++) begin
            index = index | (first_hot[i] ? IDX_W'(i) : '0);
        end
    end

endmodule

>>> src/ordered_list_insert_remove_search.sv
// Fixed-capacity ordered list held in a row of CAPACITY cells, one entry per
// cell. Each request (insert, remove, search, clear) goes through accept,
// execute (every cell at once shifts from a neighbor or compares with the
// item), then first-match encoding into the output register. A new
// request is taken in the cycle after the previous result is loaded, even while
// that result still waits on m_tready; a stalled output holds the encode step.
// Every result carries ok, the first match position (search), the removed
// value (remove), the length after the request, and empty/full flags.
module ordered_list_insert_remove_search #(
    parameter int CAPACITY      = olirs_pkg::CAPACITY_DEF,
    parameter int ELEMENT_WIDTH = olirs_pkg::ELEMENT_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [6:0] position, [38:7] item_value, [39] zero
    input  logic [olirs_pkg::S_DATA_W-1:0]  s_tdata,
    // [1:0] cmd
    input  logic [olirs_pkg::CMD_W-1:0]     s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [0] ok, [7:1] found_position, [39:8] removed_value, [46:40] length,
    // [47] is_empty, [48] is_full, [55:49] zero
    output logic [olirs_pkg::M_DATA_W-1:0]  m_tdata
);
    import olirs_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_EXEC = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg, state_next;

    op_t                      op_reg;
    logic [POS_W-1:0]         pos_reg;
    logic [VAL_W-1:0]         val_reg;
    logic [CNT_W-1:0]         count_reg, count_next;
    logic                     ok_reg;
    logic [CAPACITY-1:0]      match_reg;
    logic [VAL_W-1:0]         removed_reg;
    logic [M_DATA_W-1:0]      m_tdata_reg;
    logic                     m_tvalid_reg;

    logic [ELEMENT_WIDTH-1:0] elem_val;
    logic [ELEMENT_WIDTH-1:0] removed_elem;
    logic [VAL_W-1:0]         removed_wide;
    logic [CMP_W-1:0]         pos_ext, cnt_ext;
    logic                     ins_ok, rem_ok;
    logic [IDX_W-1:0]         k_idx;
    cell_ctrl_t               ctrl;
    logic                     in_accept;
    logic                     load_out;
    logic                     any_match;
    logic [IDX_W-1:0]         match_idx;
    logic                     ok_final;
    logic [POS_W-1:0]         found_pos;

    logic [ELEMENT_WIDTH-1:0] cell_data [CAPACITY];
    logic [ELEMENT_WIDTH-1:0] cell_sel  [CAPACITY];
    logic [CAPACITY-1:0]      cell_match;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign load_out  = (state_reg == ST_DONE) && (!m_tvalid_reg || m_tready);

    // keep only the stored width of the value, or zero-extend it when the element is wider
    if (ELEMENT_WIDTH <= VAL_W) begin : g_val_narrow
        assign elem_val = val_reg[ELEMENT_WIDTH-1:0];
    end else begin : g_val_wide
        assign elem_val = {{(ELEMENT_WIDTH - VAL_W){1'b0}}, val_reg};
    end

    if (ELEMENT_WIDTH >= VAL_W) begin : g_rem_trunc
        assign removed_wide = removed_elem[VAL_W-1:0];
    end else begin : g_rem_sext
        assign removed_wide = {{(VAL_W - ELEMENT_WIDTH){removed_elem[ELEMENT_WIDTH-1]}},
                               removed_elem};
    end

    assign pos_ext = CMP_W'(pos_reg);
    assign cnt_ext = CMP_W'(count_reg);
    assign ins_ok  = (cnt_ext < CMP_W'(CAPACITY)) && (pos_reg != '0)
                     && (pos_ext <= cnt_ext + CMP_W'(1));
    assign rem_ok  = (count_reg != '0) && (pos_reg != '0) && (pos_ext <= cnt_ext);
    assign k_idx   = IDX_W'(pos_ext - CMP_W'(1));

    always_comb begin
        ctrl.shift_ins = (state_reg == ST_EXEC) && (op_reg == OP_INSERT) && ins_ok;
        ctrl.shift_rem = (state_reg == ST_EXEC) && (op_reg == OP_REMOVE) && rem_ok;
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [ELEMENT_WIDTH-1:0] left_d, right_d;
        if (i == 0) begin : g_first
            assign left_d = '0;
        end else begin : g_mid_l
            assign left_d = cell_data[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_d = '0;
        end else begin : g_mid_r
            assign right_d = cell_data[i+1];
        end
        olirs_cell #(
            .ELEMENT_WIDTH (ELEMENT_WIDTH),
            .IDX_W         (IDX_W),
            .CNT_W         (CNT_W),
            .INDEX         (i)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .k_idx      (k_idx),
            .count      (count_reg),
            .item_val   (elem_val),
            .left_data  (left_d),
            .right_data (right_d),
            .data_out   (cell_data[i]),
            .match      (cell_match[i]),
            .sel_data   (cell_sel[i])
        );
    end

    always_comb begin
        removed_elem = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            removed_elem = removed_elem | cell_sel[i];
        end
    end

    olirs_first_match #(
        .WIDTH (CAPACITY),
        .IDX_W (IDX_W)
    ) u_first_match (
        .match (match_reg),
        .any   (any_match),
        .index (match_idx)
    );

    always_comb begin
        count_next = count_reg;
        case (op_reg)
            OP_INSERT: if (ins_ok) begin
                count_next = count_reg + CNT_W'(1);
            end
            OP_REMOVE: if (rem_ok) begin
                count_next = count_reg - CNT_W'(1);
            end
            OP_CLEAR:  count_next = '0;
            default:   count_next = count_reg;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (in_accept) begin
                state_next = ST_EXEC;
            end
            ST_EXEC: state_next = ST_DONE;
            ST_DONE: if (load_out) begin
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assign ok_final  = (op_reg == OP_SEARCH) ? any_match : ok_reg;
    assign found_pos = ((op_reg == OP_SEARCH) && any_match)
                       ? POS_W'(CNT_W'(match_idx) + CNT_W'(1)) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_EXEC) begin
                count_reg <= count_next;
            end
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            op_reg  <= op_t'(s_tuser);
            pos_reg <= s_tdata[POS_W-1:0];
            val_reg <= s_tdata[POS_W+VAL_W-1:POS_W];
        end
        if (state_reg == ST_EXEC) begin
            match_reg   <= (op_reg == OP_SEARCH) ? cell_match : '0;
            ok_reg      <= ((op_reg == OP_INSERT) && ins_ok)
                           || ((op_reg == OP_REMOVE) && rem_ok);
            removed_reg <= ((op_reg == OP_REMOVE) && rem_ok) ? removed_wide : '0;
        end
        if (load_out) begin
            m_tdata_reg <= {7'd0,
                            count_reg == CNT_W'(CAPACITY),
                            count_reg == '0,
                            POS_W'(count_reg),
                            removed_reg,
                            found_pos,
                            ok_final};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_count_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_accept_exec : assert property (@(posedge aclk) disable iff (!aresetn)
        in_accept |=> (state_reg == ST_EXEC))
        else $error("accepted request did not enter execute");

    a_stall_hold : assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE) && m_tvalid_reg && !m_tready |=> (state_reg == ST_DONE))
        else $error("result dropped while output stalled");

    a_flags : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !(m_tdata[47] && m_tdata[48]))
        else $error("list reported both empty and full");

endmodule

>>> tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import olirs_pkg::*;

    localparam int LIST_CAP    = CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct packed {
        logic             ok;
        logic [POS_W-1:0] found_pos;
        logic [VAL_W-1:0] removed;
        logic [POS_W-1:0] length;
        logic             is_empty;
        logic             is_full;
    } list_result_t;

    logic                aclk     = 1'b0;
    logic                aresetn  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [CMD_W-1:0]    s_tuser  = '0;
    logic                m_tready = 1'b1;
    logic                s_tready;
    logic                m_tvalid;
    logic [M_DATA_W-1:0] m_tdata;

    // shadow copy of the list contents, updated as each request is accepted
    logic [VAL_W-1:0] shadow_list [LIST_CAP];
    int               shadow_len = 0;
    list_result_t     expected_results [$];
    list_result_t     want_result;
    list_result_t     got_result;
    logic [VAL_W-1:0] value_pool [8];
    int               mismatch_count = 0;
    int               cycle_count    = 0;
    int               rx_hold_cycles = 0;
    bit               tx_idle_en     = 1'b0;
    bit               rx_idle_en     = 1'b0;

    ordered_list_insert_remove_search uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[ordered_list_insert_remove_search] ERROR");
            $finish;
        end
    end

    function automatic list_result_t apply_to_shadow_list(op_t op, logic [POS_W-1:0] pos,
                                                          logic [VAL_W-1:0] val);
        list_result_t res;
        int           p;
        int           j;
        res = '0;
        p = int'(pos);
        case (op)
            OP_INSERT: begin
                if (shadow_len < LIST_CAP && p >= 1 && p <= shadow_len + 1) begin
                    for (j = shadow_len; j >= p; j--)
                        shadow_list[j] = shadow_list[j-1];
                    shadow_list[p-1] = val;
                    shadow_len++;
                    res.ok = 1'b1;
                end
            end
            OP_REMOVE: begin
                if (shadow_len > 0 && p >= 1 && p <= shadow_len) begin
                    res.removed = shadow_list[p-1];
                    for (j = p; j < shadow_len; j++)
                        shadow_list[j-1] = shadow_list[j];
                    shadow_len--;
                    res.ok = 1'b1;
                end
            end
            OP_SEARCH: begin
                for (j = 0; j < shadow_len; j++) begin
                    if (!res.ok && shadow_list[j] == val) begin
                        res.found_pos = POS_W'(j + 1);
                        res.ok = 1'b1;
                    end
                end
            end
            default: begin
                shadow_len = 0;
            end
        endcase
        res.length   = POS_W'(shadow_len);
        res.is_empty = (shadow_len == 0);
        res.is_full  = (shadow_len == LIST_CAP);
        return res;
    endfunction

    task automatic compare_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
        if (got !== want) begin
            mismatch_count++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                mismatch_count++;
                $display("%0t: result %h with no request pending", $time, m_tdata);
            end else begin
                want_result = expected_results.pop_front();
                got_result  = {m_tdata[0], m_tdata[7:1], m_tdata[39:8], m_tdata[46:40],
                               m_tdata[47], m_tdata[48]};
                compare_field("ok", VAL_W'(want_result.ok), VAL_W'(got_result.ok));
                compare_field("found_position", VAL_W'(want_result.found_pos),
                              VAL_W'(got_result.found_pos));
                compare_field("removed_value", want_result.removed, got_result.removed);
                compare_field("length", VAL_W'(want_result.length), VAL_W'(got_result.length));
                compare_field("is_empty", VAL_W'(want_result.is_empty),
                              VAL_W'(got_result.is_empty));
                compare_field("is_full", VAL_W'(want_result.is_full),
                              VAL_W'(got_result.is_full));
            end
        end
    end

    // receiver: random stalls, plus one long hold-off counted here
    initial begin
        forever begin
            @(posedge aclk);
            if (rx_hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (rx_hold_cycles) @(posedge aclk);
                rx_hold_cycles = 0;
                m_tready <= 1'b1;
            end else if (rx_idle_en && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 17)) @(posedge aclk);
                m_tready <= 1'b1;
            end
        end
    end

    // hold the request until accepted, then maybe leave a gap
    task automatic issue_request(op_t op, logic [POS_W-1:0] pos, logic [VAL_W-1:0] val);
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, val, pos};
        s_tuser  <= op;
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(apply_to_shadow_list(op, pos, val));
        if (tx_idle_en && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge aclk);
        end
    endtask

    // pool values give duplicates, so first-match search gets exercised
    function automatic logic [VAL_W-1:0] pick_value();
        if ($urandom_range(0, 1) == 0)
            return value_pool[$urandom_range(0, 7)];
        return $urandom;
    endfunction

    function automatic logic [VAL_W-1:0] pick_search_value();
        if (shadow_len > 0 && $urandom_range(0, 9) < 6)
            return shadow_list[$urandom_range(0, shadow_len - 1)];
        return pick_value();
    endfunction

    task automatic random_list_request(bit growing);
        int r;
        int insert_weight;
        r = $urandom_range(0, 99);
        insert_weight = growing ? 55 : 20;
        if (r < 5) begin
            issue_request(op_t'($urandom_range(0, 3)), POS_W'($urandom_range(0, 127)),
                          $urandom);
        end else if (r == 5 && !growing) begin
            issue_request(OP_CLEAR, POS_W'($urandom_range(0, 127)), $urandom);
        end else begin
            r = $urandom_range(0, 99);
            if (r < insert_weight)
                issue_request(OP_INSERT, POS_W'($urandom_range(1, shadow_len + 1)),
                              pick_value());
            else if (r < 75)
                issue_request(OP_REMOVE,
                              POS_W'((shadow_len == 0) ? 1 : $urandom_range(1, shadow_len)),
                              pick_value());
            else
                issue_request(OP_SEARCH, POS_W'($urandom_range(0, 127)), pick_search_value());
        end
    endtask

    task automatic run_directed_edges();
        issue_request(OP_SEARCH, 0, 32'h0000_0000);
        issue_request(OP_REMOVE, 1, 32'h0000_0000);
        issue_request(OP_INSERT, 0, 32'h1111_1111);
        issue_request(OP_INSERT, 2, 32'h2222_2222);
        issue_request(OP_INSERT, 1, 32'h8000_0000);
        issue_request(OP_INSERT, 2, 32'h7fff_ffff);
        issue_request(OP_INSERT, 1, 32'hffff_ffff);
        issue_request(OP_INSERT, 2, 32'h0000_0000);
        issue_request(OP_INSERT, 127, 32'h5555_5555);
        issue_request(OP_INSERT, 5, 32'h7fff_ffff);
        issue_request(OP_SEARCH, 127, 32'h7fff_ffff);
        issue_request(OP_SEARCH, 0, 32'h1234_5678);
        issue_request(OP_SEARCH, 3, 32'h8000_0000);
        issue_request(OP_REMOVE, 0, 32'hffff_ffff);
        issue_request(OP_REMOVE, 6, 32'h0000_0000);
        issue_request(OP_REMOVE, 127, 32'h0000_0000);
        issue_request(OP_REMOVE, 5, 32'h0000_0000);
        issue_request(OP_REMOVE, 1, 32'h0000_0000);
        issue_request(OP_CLEAR, 127, 32'hffff_ffff);
        issue_request(OP_SEARCH, 0, 32'h8000_0000);
        issue_request(OP_REMOVE, 1, 32'h0000_0000);
    endtask

    task automatic run_fill_to_capacity();
        while (shadow_len < LIST_CAP)
            issue_request(OP_INSERT, POS_W'($urandom_range(1, shadow_len + 1)), pick_value());
        issue_request(OP_INSERT, 1, 32'haaaa_aaaa);
        issue_request(OP_INSERT, POS_W'(LIST_CAP + 1), 32'haaaa_aaaa);
        issue_request(OP_SEARCH, 0, shadow_list[LIST_CAP-1]);
        issue_request(OP_SEARCH, 0, shadow_list[0]);
        issue_request(OP_REMOVE, POS_W'(LIST_CAP), 32'h0000_0000);
        issue_request(OP_INSERT, POS_W'(LIST_CAP), 32'h8000_0001);
        while (shadow_len > 0)
            issue_request(OP_REMOVE, POS_W'($urandom_range(1, shadow_len)), $urandom);
    endtask

    task automatic run_random_mix();
        bit growing;
        int i;
        growing = 1'b1;
        for (i = 0; i < 350; i++) begin
            if (i % 60 == 0) begin
                tx_idle_en = ($urandom_range(0, 3) != 0);
                rx_idle_en = ($urandom_range(0, 3) != 0);
            end
            if (shadow_len == LIST_CAP)
                growing = 1'b0;
            else if (shadow_len == 0)
                growing = 1'b1;
            else if ($urandom_range(0, 99) == 0)
                growing = !growing;
            random_list_request(growing);
        end
    endtask

    // stall the output long enough that the input backs up behind it
    task automatic run_output_backpressure();
        int i;
        tx_idle_en = 1'b0;
        rx_hold_cycles = 400;
        for (i = 0; i < 30; i++)
            random_list_request(shadow_len < LIST_CAP / 2);
    endtask

    task automatic run_steady_stream();
        int i;
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        for (i = 0; i < 80; i++)
            random_list_request(shadow_len < LIST_CAP / 2);
    endtask

    initial begin
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7fff_ffff;
        for (int k = 2; k < 8; k++)
            value_pool[k] = $urandom;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        run_directed_edges();
        run_fill_to_capacity();
        run_random_mix();
        run_output_backpressure();
        run_steady_stream();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("[ordered_list_insert_remove_search] OK");
        end else begin
            $display("[ordered_list_insert_remove_search] ERROR");
        end
        $finish;
    end

endmodule

>>> sim.f
src/olirs_pkg.sv
src/olirs_cell.sv
src/olirs_first_match.sv
src/ordered_list_insert_remove_search.sv
tb/tb.sv
